>>> design/pps_pkg.sv
package pps_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int ID_BITS       = 16;
  localparam int PRIO_BITS     = 8;

  localparam int SLOT_BITS  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_BITS   = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_BITS = ID_BITS + PRIO_BITS;

  typedef enum logic [1:0] {
    ACT_STOP   = 2'd0,
    ACT_CONT   = 2'd1,
    ACT_REJECT = 2'd2
  } action_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic id_eq;
    logic prio_gt;
  } cmp_res_t;

endpackage

>>> design/pps_ram.sv
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/pps_cmp.sv
module pps_cmp (
  input  pps_pkg::entry_t                  a_i,
  input  logic [pps_pkg::ID_BITS-1:0]      key_id_i,
  input  logic [pps_pkg::PRIO_BITS-1:0]    b_prio_i,
  output pps_pkg::cmp_res_t                res_o
);

  // shared between remove match, best-entry scan and preemption check
  assign res_o.id_eq   = (a_i.id == key_id_i);
  assign res_o.prio_gt = (a_i.prio > b_prio_i);

endmodule

>>> design/preemptive_priority_scheduler_core.sv
// Channel | Direction | Handshake                 | Beat fields
// in      | input     | in_valid_i / in_stall_o   | opcode_i, task_id_i, task_priority_i
// out     | output    | out_valid_o / out_stall_i | action_o, target_id_o, last_of_run_o
//
// One beat at a time; in_stall_o is high from acceptance until the FSM is back in idle.
// Insert: table write (none when full), best-entry scan, decide, then one to three emit beats.
// Remove: match scan, best-entry scan, decide, then emit (at most one beat).
// Both scans go through the registered table read.
// Reset clears the valid bits and the running mark; output stalls stretch the emit phase.
module preemptive_priority_scheduler_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             opcode_i,
  input  logic [pps_pkg::ID_BITS-1:0]      task_id_i,
  input  logic [pps_pkg::PRIO_BITS-1:0]    task_priority_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       action_o,
  output logic [pps_pkg::ID_BITS-1:0]      target_id_o,
  output logic                             last_of_run_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_REM,
    ST_SEL,
    ST_DEC,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  logic [pps_pkg::TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic                              run_valid_q, run_valid_d;
  logic [pps_pkg::SLOT_BITS-1:0]     run_slot_q, run_slot_d;

  logic [pps_pkg::ID_BITS-1:0]       id_q, id_d;
  logic [pps_pkg::PRIO_BITS-1:0]     prio_q, prio_d;

  logic [pps_pkg::CNT_BITS-1:0]      cnt_q, cnt_d;
  logic                              chk_vld_q, chk_vld_d;
  logic [pps_pkg::SLOT_BITS-1:0]     chk_slot_q, chk_slot_d;
  logic                              done_q, done_d;

  logic                              found_q, found_d;
  logic [pps_pkg::SLOT_BITS-1:0]     best_slot_q, best_slot_d;
  logic [pps_pkg::ID_BITS-1:0]       best_id_q, best_id_d;
  logic [pps_pkg::PRIO_BITS-1:0]     best_prio_q, best_prio_d;
  logic [pps_pkg::ID_BITS-1:0]       run_id_q, run_id_d;
  logic [pps_pkg::PRIO_BITS-1:0]     run_prio_q, run_prio_d;

  pps_pkg::action_e                  ins_act_q, ins_act_d;
  logic                              e_ins_q, e_ins_d;
  logic                              e_stop_q, e_stop_d;
  logic                              e_cont_q, e_cont_d;

  logic                              out_valid_q, out_valid_d;
  pps_pkg::action_e                  act_q, act_d;
  logic [pps_pkg::ID_BITS-1:0]       tgt_q, tgt_d;
  logic                              last_q, last_d;

  logic                              ram_we;
  logic [pps_pkg::SLOT_BITS-1:0]     ram_waddr;
  pps_pkg::entry_t                   ram_wentry;
  logic [pps_pkg::SLOT_BITS-1:0]     ram_raddr;
  logic [pps_pkg::ENTRY_BITS-1:0]    ram_rdata;
  pps_pkg::entry_t                   rd_entry;

  pps_pkg::entry_t                   cmp_a;
  logic [pps_pkg::PRIO_BITS-1:0]     cmp_b_prio;
  pps_pkg::cmp_res_t                 cmp_res;

  logic                              free_any;
  logic [pps_pkg::SLOT_BITS-1:0]     free_slot;
  logic                              issue;
  logic                              out_free;

  pps_ram #(
    .WIDTH (pps_pkg::ENTRY_BITS),
    .DEPTH (pps_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = pps_pkg::entry_t'(ram_rdata);

  pps_cmp u_cmp (
    .a_i      (cmp_a),
    .key_id_i (id_q),
    .b_prio_i (cmp_b_prio),
    .res_o    (cmp_res)
  );

  always_comb begin
    if (state_q == ST_DEC) begin
      cmp_a.id   = best_id_q;
      cmp_a.prio = best_prio_q;
      cmp_b_prio = run_prio_q;
    end else begin
      cmp_a      = rd_entry;
      cmp_b_prio = best_prio_q;
    end
  end

  // lowest free slot
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = pps_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any  = 1'b1;
        free_slot = pps_pkg::SLOT_BITS'(i);
      end
    end
  end

  assign issue     = (cnt_q < pps_pkg::CNT_BITS'(pps_pkg::TABLE_ENTRIES));
  assign ram_raddr = cnt_q[pps_pkg::SLOT_BITS-1:0];
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    run_valid_d = run_valid_q;
    run_slot_d  = run_slot_q;
    id_d        = id_q;
    prio_d      = prio_q;
    cnt_d       = cnt_q;
    chk_vld_d   = 1'b0;
    chk_slot_d  = chk_slot_q;
    done_d      = done_q;
    found_d     = found_q;
    best_slot_d = best_slot_q;
    best_id_d   = best_id_q;
    best_prio_d = best_prio_q;
    run_id_d    = run_id_q;
    run_prio_d  = run_prio_q;
    ins_act_d   = ins_act_q;
    e_ins_d     = e_ins_q;
    e_stop_d    = e_stop_q;
    e_cont_d    = e_cont_q;
    out_valid_d = out_valid_q && out_stall_i;
    act_d       = act_q;
    tgt_d       = tgt_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_waddr   = free_slot;
    ram_wentry.id   = id_q;
    ram_wentry.prio = prio_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          id_d     = task_id_i;
          prio_d   = task_priority_i;
          e_ins_d  = 1'b0;
          e_stop_d = 1'b0;
          e_cont_d = 1'b0;
          cnt_d    = '0;
          done_d   = 1'b0;
          state_d  = (opcode_i == pps_pkg::OP_INSERT) ? ST_INS : ST_REM;
        end
      end

      ST_INS: begin
        e_ins_d = 1'b1;
        if (free_any) begin
          ram_we             = 1'b1;
          valid_d[free_slot] = 1'b1;
          ins_act_d          = pps_pkg::ACT_STOP;
        end else begin
          ins_act_d          = pps_pkg::ACT_REJECT;
        end
        cnt_d   = '0;
        found_d = 1'b0;
        state_d = ST_SEL;
      end

      ST_REM: begin
        if (issue) begin
          cnt_d      = cnt_q + 1'b1;
          chk_vld_d  = 1'b1;
          chk_slot_d = ram_raddr;
        end
        if (chk_vld_q && !done_q && valid_q[chk_slot_q] && cmp_res.id_eq) begin
          valid_d[chk_slot_q] = 1'b0;
          done_d              = 1'b1;
          if (run_valid_q && run_slot_q == chk_slot_q) begin
            run_valid_d = 1'b0;
          end
        end
        if (!issue && !chk_vld_q) begin
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = ST_SEL;
        end
      end

      ST_SEL: begin
        if (issue) begin
          cnt_d      = cnt_q + 1'b1;
          chk_vld_d  = 1'b1;
          chk_slot_d = ram_raddr;
        end
        if (chk_vld_q && valid_q[chk_slot_q]) begin
          if (!found_q || cmp_res.prio_gt) begin
            found_d     = 1'b1;
            best_slot_d = chk_slot_q;
            best_id_d   = rd_entry.id;
            best_prio_d = rd_entry.prio;
          end
          if (run_valid_q && run_slot_q == chk_slot_q) begin
            run_id_d   = rd_entry.id;
            run_prio_d = rd_entry.prio;
          end
        end
        if (!issue && !chk_vld_q) begin
          state_d = ST_DEC;
        end
      end

      ST_DEC: begin
        if (found_q) begin
          if (!run_valid_q) begin
            run_valid_d = 1'b1;
            run_slot_d  = best_slot_q;
            e_cont_d    = 1'b1;
          end else if (cmp_res.prio_gt) begin
            run_slot_d = best_slot_q;
            e_stop_d   = 1'b1;
            e_cont_d   = 1'b1;
          end
        end
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        // results go out in order: insert outcome, stop old task, continue new task
        priority if (!e_ins_q && !e_stop_q && !e_cont_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          priority if (e_ins_q) begin
            act_d   = ins_act_q;
            tgt_d   = id_q;
            last_d  = !e_stop_q && !e_cont_q;
            e_ins_d = 1'b0;
            if (!e_stop_q && !e_cont_q) begin
              state_d = ST_IDLE;
            end
          end else if (e_stop_q) begin
            act_d    = pps_pkg::ACT_STOP;
            tgt_d    = run_id_q;
            last_d   = !e_cont_q;
            e_stop_d = 1'b0;
            if (!e_cont_q) begin
              state_d = ST_IDLE;
            end
          end else begin
            act_d    = pps_pkg::ACT_CONT;
            tgt_d    = best_id_q;
            last_d   = 1'b1;
            e_cont_d = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      chk_vld_q   <= 1'b0;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      found_q     <= 1'b0;
      e_ins_q     <= 1'b0;
      e_stop_q    <= 1'b0;
      e_cont_q    <= 1'b0;
      out_valid_q <= 1'b0;
      id_q        <= '0;
      prio_q      <= '0;
      chk_slot_q  <= '0;
      best_slot_q <= '0;
      best_id_q   <= '0;
      best_prio_q <= '0;
      run_id_q    <= '0;
      run_prio_q  <= '0;
      ins_act_q   <= pps_pkg::ACT_STOP;
      act_q       <= pps_pkg::ACT_STOP;
      tgt_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      run_valid_q <= run_valid_d;
      run_slot_q  <= run_slot_d;
      chk_vld_q   <= chk_vld_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
      found_q     <= found_d;
      e_ins_q     <= e_ins_d;
      e_stop_q    <= e_stop_d;
      e_cont_q    <= e_cont_d;
      out_valid_q <= out_valid_d;
      id_q        <= id_d;
      prio_q      <= prio_d;
      chk_slot_q  <= chk_slot_d;
      best_slot_q <= best_slot_d;
      best_id_q   <= best_id_d;
      best_prio_q <= best_prio_d;
      run_id_q    <= run_id_d;
      run_prio_q  <= run_prio_d;
      ins_act_q   <= ins_act_d;
      act_q       <= act_d;
      tgt_q       <= tgt_d;
      last_q      <= last_d;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign action_o      = act_q;
  assign target_id_o   = tgt_q;
  assign last_of_run_o = last_q;

endmodule

>>> verif/tb.sv
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 40;
  localparam int RESET_CYCLES = 12;

  typedef struct {
    pps_pkg::action_e            act;
    logic [pps_pkg::ID_BITS-1:0] id;
    logic                        last;
  } sched_action_t;

  logic                          clk = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic                          opcode_i;
  logic [pps_pkg::ID_BITS-1:0]   task_id_i;
  logic [pps_pkg::PRIO_BITS-1:0] task_priority_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [1:0]                    action_o;
  logic [pps_pkg::ID_BITS-1:0]   target_id_o;
  logic                          last_of_run_o;

  // predictor state
  bit                            slot_valid [pps_pkg::TABLE_ENTRIES];
  logic [pps_pkg::ID_BITS-1:0]   slot_id    [pps_pkg::TABLE_ENTRIES];
  logic [pps_pkg::PRIO_BITS-1:0] slot_prio  [pps_pkg::TABLE_ENTRIES];
  bit                            run_valid;
  int                            run_slot;

  sched_action_t pending_actions[$];
  sched_action_t want;

  int mismatches;
  int events_sent;
  int actions_seen;
  int rejects_seen;
  int preemptions;
  int cycles;

  bit          tx_quiet;
  bit          rx_quiet;
  int unsigned rx_wait;
  int unsigned rx_hold;

  preemptive_priority_scheduler_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .task_id_i       (task_id_i),
    .task_priority_i (task_priority_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .action_o        (action_o),
    .target_id_o     (target_id_o),
    .last_of_run_o   (last_of_run_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d actions outstanding", cycles,
               pending_actions.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0d] mismatch: %s", cycles, what);
  endtask

  function automatic int unsigned draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic sched_action_t mk_action(pps_pkg::action_e act,
                                              logic [pps_pkg::ID_BITS-1:0] id);
    sched_action_t a;
    a.act  = act;
    a.id   = id;
    a.last = 1'b0;
    return a;
  endfunction

  function automatic int slots_used();
    int n;
    n = 0;
    for (int i = 0; i < pps_pkg::TABLE_ENTRIES; i++) n += slot_valid[i];
    return n;
  endfunction

  // Applies one event to the shadow table and queues the actions it should cause.
  task automatic predict_dispatch(pps_pkg::opcode_e op, logic [pps_pkg::ID_BITS-1:0] id,
                                  logic [pps_pkg::PRIO_BITS-1:0] prio);
    sched_action_t run_q[$];
    bit            done;
    int            best;
    done = 1'b0;
    best = -1;
    if (op == pps_pkg::OP_INSERT) begin
      for (int i = 0; i < pps_pkg::TABLE_ENTRIES; i++) begin
        if (!done && !slot_valid[i]) begin
          slot_valid[i] = 1'b1;
          slot_id[i]    = id;
          slot_prio[i]  = prio;
          done          = 1'b1;
        end
      end
      if (done) run_q.push_back(mk_action(pps_pkg::ACT_STOP, id));
      else run_q.push_back(mk_action(pps_pkg::ACT_REJECT, id));
    end else begin
      // only the lowest matching slot is freed
      for (int i = 0; i < pps_pkg::TABLE_ENTRIES; i++) begin
        if (!done && slot_valid[i] && slot_id[i] == id) begin
          slot_valid[i] = 1'b0;
          if (run_valid && run_slot == i) run_valid = 1'b0;
          done = 1'b1;
        end
      end
    end
    for (int i = 0; i < pps_pkg::TABLE_ENTRIES; i++) begin
      if (slot_valid[i] && (best < 0 || slot_prio[i] > slot_prio[best])) best = i;
    end
    if (best >= 0) begin
      if (!run_valid) begin
        run_valid = 1'b1;
        run_slot  = best;
        run_q.push_back(mk_action(pps_pkg::ACT_CONT, slot_id[best]));
      end else if (slot_prio[run_slot] < slot_prio[best]) begin
        run_q.push_back(mk_action(pps_pkg::ACT_STOP, slot_id[run_slot]));
        run_slot = best;
        run_q.push_back(mk_action(pps_pkg::ACT_CONT, slot_id[best]));
        preemptions++;
      end
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
    foreach (run_q[k]) pending_actions.push_back(run_q[k]);
  endtask

  // Offers one beat; returns at the edge where it is taken.
  task automatic send_event(pps_pkg::opcode_e op, logic [pps_pkg::ID_BITS-1:0] id,
                            logic [pps_pkg::PRIO_BITS-1:0] prio);
    int unsigned gap;
    gap = draw_wait(tx_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode_i        = op;
    task_id_i       = id;
    task_priority_i = prio;
    in_valid_i      = 1'b1;
    do @(posedge clk); while (in_stall_o);
    predict_dispatch(op, id, prio);
    events_sent++;
  endtask

  task automatic drain_events();
    @(negedge clk);
    in_valid_i = 1'b0;
    while (pending_actions.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // receiver stall drive
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall_i = 1'b1;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_stall_i = 1'b1;
        rx_wait--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      actions_seen++;
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("unexpected beat action=%0d id=%h last=%b",
                                  action_o, target_id_o, last_of_run_o));
      end else begin
        want = pending_actions.pop_front();
        if (want.act == pps_pkg::ACT_REJECT) rejects_seen++;
        if (action_o !== want.act)
          report_mismatch($sformatf("action %0d, want %0d (id %h)",
                                    action_o, want.act, want.id));
        if (target_id_o !== want.id)
          report_mismatch($sformatf("target_id %h, want %h", target_id_o, want.id));
        if (last_of_run_o !== want.last)
          report_mismatch($sformatf("last_of_run %b, want %b (id %h)",
                                    last_of_run_o, want.last, want.id));
      end
      rx_wait = draw_wait(rx_quiet);
    end
  end

  // ties, preemption, duplicates, absent ids, full table, draining to empty
  task automatic test_directed();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    send_event(pps_pkg::OP_INSERT, 16'h0000, 8'd0);
    send_event(pps_pkg::OP_INSERT, 16'hffff, 8'd255);
    send_event(pps_pkg::OP_INSERT, 16'h1234, 8'd255);
    send_event(pps_pkg::OP_REMOVE, 16'h7777, 8'd0);
    send_event(pps_pkg::OP_REMOVE, 16'hffff, 8'hff);
    send_event(pps_pkg::OP_INSERT, 16'h1234, 8'd255);
    send_event(pps_pkg::OP_REMOVE, 16'h1234, 8'd9);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    send_event(pps_pkg::OP_INSERT, 16'haaaa, 8'd128);
    send_event(pps_pkg::OP_INSERT, 16'h5555, 8'd1);
    send_event(pps_pkg::OP_INSERT, 16'h00ff, 8'd254);
    send_event(pps_pkg::OP_INSERT, 16'hff00, 8'd0);
    send_event(pps_pkg::OP_INSERT, 16'h0001, 8'd200);
    send_event(pps_pkg::OP_INSERT, 16'h8000, 8'd127);
    send_event(pps_pkg::OP_INSERT, 16'h7fff, 8'd255);
    send_event(pps_pkg::OP_REMOVE, 16'h1234, 8'd0);
    send_event(pps_pkg::OP_REMOVE, 16'h0000, 8'd0);
    send_event(pps_pkg::OP_REMOVE, 16'h00ff, 8'd0);
    send_event(pps_pkg::OP_REMOVE, 16'haaaa, 8'd0);
    send_event(pps_pkg::OP_REMOVE, 16'h5555, 8'd0);
    send_event(pps_pkg::OP_REMOVE, 16'hff00, 8'd0);
    send_event(pps_pkg::OP_REMOVE, 16'h0001, 8'd0);
    send_event(pps_pkg::OP_REMOVE, 16'h8000, 8'd0);
    send_event(pps_pkg::OP_REMOVE, 16'h8000, 8'd0);
  endtask

  task automatic test_random_mix(int n_items);
    int unsigned                   roll;
    int                            fill;
    int                            pick;
    logic [pps_pkg::ID_BITS-1:0]   id;
    logic [pps_pkg::PRIO_BITS-1:0] prio;
    for (int k = 0; k < n_items; k++) begin
      // stretches: no idling at all, sender only, then both sides
      tx_quiet = (k < n_items / 5);
      rx_quiet = (k < 2 * n_items / 5);
      fill = slots_used();
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) prio = pps_pkg::PRIO_BITS'($urandom_range(0, 3));
      else prio = pps_pkg::PRIO_BITS'($urandom_range(0, 255));
      if (roll < 10) begin
        // stray remove, almost always of an absent id
        send_event(pps_pkg::OP_REMOVE, pps_pkg::ID_BITS'($urandom_range(0, 65535)), prio);
      end else if (fill == 0 ||
                   (fill < pps_pkg::TABLE_ENTRIES ? roll < 60 : roll < 25)) begin
        id = pps_pkg::ID_BITS'($urandom_range(0, 65535));
        if (fill > 0 && $urandom_range(0, 3) == 0) begin
          pick = $urandom_range(0, pps_pkg::TABLE_ENTRIES - 1);
          while (!slot_valid[pick]) pick = (pick + 1) % pps_pkg::TABLE_ENTRIES;
          id = slot_id[pick];
        end
        send_event(pps_pkg::OP_INSERT, id, prio);
      end else begin
        pick = $urandom_range(0, pps_pkg::TABLE_ENTRIES - 1);
        while (!slot_valid[pick]) pick = (pick + 1) % pps_pkg::TABLE_ENTRIES;
        send_event(pps_pkg::OP_REMOVE, slot_id[pick], prio);
      end
    end
  endtask

  // long output hold while the sender keeps offering back to back
  task automatic test_backpressure();
    tx_quiet = 1'b1;
    rx_quiet = 1'b0;
    @(posedge clk);
    rx_hold = 200;
    for (int k = 0; k < 6; k++)
      send_event(pps_pkg::OP_INSERT, pps_pkg::ID_BITS'($urandom_range(0, 65535)),
                 pps_pkg::PRIO_BITS'($urandom_range(0, 255)));
    for (int k = 0; k < pps_pkg::TABLE_ENTRIES; k++) begin
      if (slot_valid[k]) send_event(pps_pkg::OP_REMOVE, slot_id[k], 8'd0);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    opcode_i        = pps_pkg::OP_INSERT;
    task_id_i       = '0;
    task_priority_i = '0;
    tx_quiet        = 1'b1;
    rx_quiet        = 1'b1;
    rx_wait         = 0;
    rx_hold         = 0;
    run_valid       = 1'b0;
    run_slot        = 0;
    for (int i = 0; i < pps_pkg::TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_ni = 1'b1;

    test_directed();
    drain_events();
    test_random_mix(100);
    drain_events();
    test_backpressure();
    drain_events();

    if (pending_actions.size() != 0)
      report_mismatch($sformatf("%0d actions never arrived", pending_actions.size()));
    $display("summary: %0d events, %0d actions checked, %0d rejects, %0d preemptions",
             events_sent, actions_seen, rejects_seen, preemptions);
    $display("summary: random gaps and stalls on both sides, one long output hold");
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
